[rtl/gsp_pkg.sv]
// ----------------------------------------------------------------------------
// gsp_pkg: shared constants and types of the splat preprocessor
// Fixed-point constants of the exponential unit and its result type.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

   // ln(2) in Q40
   localparam logic [39:0] LN2_Q40 = 40'hB1_7217_F7D2;

   // 12*ln(2) in Q40, keeps the reduced argument positive
   localparam logic [43:0] EXP_OFFSET = 44'(64'd12 * 64'(LN2_Q40));

   // floor(2^60 / LN2_Q40): reciprocal used to estimate the ln2 quotient
   localparam logic [20:0] K_RECIP = 21'((61'd1 << 60) / 61'(LN2_Q40));

   // Taylor series of e^r after the constant term
   localparam int TAYLOR_TERMS = 12;

   // register stages from the argument to the result of the exponential unit
   localparam int EXP_LATENCY = 4 + 3 * TAYLOR_TERMS;

   // floor(2^31 / i) for i = 1 .. 12
   localparam logic [31:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
      32'd2147483648, 32'd1073741824, 32'd715827882, 32'd536870912,
      32'd429496729,  32'd357913941,  32'd306783378, 32'd268435456,
      32'd238609294,  32'd214748364,  32'd195225786, 32'd178956970
   };

   // exp(v/4096) = mant * 2^(expo - 42), mant in Q30
   typedef struct packed {
      logic [31:0] mant;
      logic [5:0]  expo;
   } exp_result_type;

endpackage

`default_nettype wire

[rtl/gaussian_splat_preprocess_top.sv]
// ----------------------------------------------------------------------------
// gaussian_splat_preprocess_top: Gaussian splat preprocessor
// Scales, rotation matrix, point size, colour and opacity for one splat.
// ----------------------------------------------------------------------------
// One splat is taken at every rising edge at which start is high; busy is
// tied low, so a new splat may follow in every cycle. Each result appears on
// the rsp_ ports for exactly one cycle with rsp_strobe high, in input order;
// the receiver must take it then, as nothing downstream can hold it. The
// pipeline depth is set by the five pipelined exponential units (40 stages:
// four of range reduction, then twelve Taylor terms of three stages each, a
// term multiply, a 31x32 reciprocal multiply and a correction per term) and
// the 16-stage restoring divider of the sigmoid.
// csr_ready is always high; write splat_size_scale only while no splat is
// in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_splat_preprocess_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [47:0]        req_position,
   input  logic signed [15:0] req_log_scale_x,
   input  logic signed [15:0] req_log_scale_y,
   input  logic signed [15:0] req_log_scale_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic [47:0]        req_sh_dc_rgb,
   input  logic signed [15:0] req_opacity_logit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_strobe,
   output logic [47:0]        rsp_center,
   output logic [31:0]        rsp_point_size,
   output logic [47:0]        rsp_matrix_row0,
   output logic [47:0]        rsp_matrix_row1,
   output logic [47:0]        rsp_matrix_row2,
   output logic [63:0]        rsp_color_rgba
);

   // Stage map (stage 0 = input registers):
   //   1      max log-scale and exponent arguments, colour product
   //   2      colour clamp and scale
   //   2..41  exponential units
   //   39..41 rotation products, entries, magnitudes
   //   42     matrix / size products, sigmoid divisor
   //   43     matrix and size shift + saturate
   //   43..58 sigmoid divider, one quotient bit per stage
   //   59     output registers
   localparam int S_EXP    = 1 + gsp_pkg::EXP_LATENCY;
   localparam int S_MUL    = S_EXP + 1;
   localparam int DIV_BITS = 16;
   localparam int S_LAST   = S_MUL + DIV_BITS;
   localparam int CTR_DLY  = S_LAST;
   localparam int COL_DLY  = S_LAST - 2;
   localparam int QUAT_DLY = S_EXP - 3;
   localparam int MAT_DLY  = S_LAST - S_MUL - 1;

   localparam logic signed [33:0] ROT_ONE = 34'sd268435456;   // 1.0 in Q28
   localparam logic signed [39:0] C0_Q24  = 40'sd4732765;     // 1/(2 sqrt(pi))
   localparam logic signed [39:0] COL_ONE = 40'sd68719476736; // 1.0 in Q36

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   // control
   logic        vld_ff [S_LAST+1];
   logic        rsp_strobe_ff;
   logic [15:0] scale_ff;

   // stage 0
   logic [47:0]        pos_ff;
   logic signed [15:0] ls_ff [3];
   quat_type           quat_ff;
   logic [47:0]        sh_ff;
   logic signed [15:0] logit_ff;

   // stage 1
   logic signed [15:0] lmax;
   logic signed [17:0] arg_pk_ff;
   logic signed [17:0] arg_m_ff [3];
   logic signed [17:0] arg_a_ff;
   logic signed [39:0] col_t_in [3];
   logic signed [39:0] col_t_ff [3];

   // stage 2
   logic [36:0] col_clamp [3];
   logic [52:0] col_scaled [3];
   logic [47:0] col_c_in;
   logic [47:0] col_c_ff;

   // exponentials
   gsp_pkg::exp_result_type size_exp;
   gsp_pkg::exp_result_type col_exp [3];
   gsp_pkg::exp_result_type alpha_exp;

   // rotation
   quat_type           qd;
   logic signed [31:0] p_xx_ff, p_yy_ff, p_zz_ff;
   logic signed [31:0] p_xy_ff, p_xz_ff, p_yz_ff;
   logic signed [31:0] p_xw_ff, p_yw_ff, p_zw_ff;
   logic signed [33:0] rot_in [9];
   logic signed [33:0] rot_ff [9];
   logic [32:0]        mag_ff [9];
   logic               neg_ff [9];

   // matrix and size
   logic [63:0]        mprod_ff [9];
   logic               neg42_ff [9];
   logic [5:0]         kcol_ff [3];
   logic [63:0]        mshift [9];
   logic [15:0]        ment [9];
   logic [2:0][47:0]   mrow_in;
   logic [2:0][47:0]   mrow_ff;
   logic [47:0]        psprod_ff;
   logic [5:0]         pk42_ff;
   logic [47:0]        psshift;
   logic [31:0]        ps_in;
   logic [31:0]        ps_ff;

   // sigmoid divider
   logic [5:0]  ek;
   logic [43:0] dscaled;
   logic [46:0] dv_rem_in [DIV_BITS+1];
   logic [43:0] dv_d_in   [DIV_BITS+1];
   logic [15:0] dv_q_in   [DIV_BITS+1];
   logic [46:0] dv_rem_ff [DIV_BITS+1];
   logic [43:0] dv_d_ff   [DIV_BITS+1];
   logic [15:0] dv_q_ff   [DIV_BITS+1];
   logic [59:0] dv_sub    [DIV_BITS+1];

   // delay lines
   logic [47:0]      ctr_dly_ff  [CTR_DLY];
   logic [47:0]      col_dly_ff  [COL_DLY];
   quat_type         quat_dly_ff [QUAT_DLY];
   logic [2:0][47:0] mrow_dly_ff [MAT_DLY];
   logic [31:0]      ps_dly_ff   [MAT_DLY];

   // outputs
   logic [47:0] rsp_center_ff;
   logic [31:0] rsp_point_size_ff;
   logic [2:0][47:0] rsp_mrow_ff;
   logic [63:0] rsp_color_ff;

   // never stall the intake; config is always taken
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n <= S_LAST; n++) begin
            vld_ff[n] <= 1'b0;
         end
         rsp_strobe_ff <= 1'b0;
         scale_ff      <= 16'd256;
      end else begin
         vld_ff[0] <= start && !busy;
         for (int n = 1; n <= S_LAST; n++) begin
            vld_ff[n] <= vld_ff[n-1];
         end
         rsp_strobe_ff <= vld_ff[S_LAST];
         if (csr_valid && csr_ready) begin
            scale_ff <= csr_wdata;
         end
      end
   end

   // ------------------------------------------------------ stage 1 / 2 logic
   always_comb begin
      lmax = ls_ff[0];
      if (ls_ff[1] > lmax) begin
         lmax = ls_ff[1];
      end
      if (ls_ff[2] > lmax) begin
         lmax = ls_ff[2];
      end
   end

   always_comb begin
      col_c_in = '0;
      for (int c = 0; c < 3; c++) begin
         // DC * C0 + 0.5 in Q36
         col_t_in[c] = 40'($signed(sh_ff[16*c +: 16])) * C0_Q24 + 40'sd34359738368;
         // clamp to [0, 1], then scale by 65535 and round half up
         if (col_t_ff[c][39]) begin
            col_clamp[c] = '0;
         end else if (col_t_ff[c] > COL_ONE) begin
            col_clamp[c] = 37'd1 << 36;
         end else begin
            col_clamp[c] = col_t_ff[c][36:0];
         end
         col_scaled[c] = (53'(col_clamp[c]) << 16) - 53'(col_clamp[c]) + (53'd1 << 35);
         col_c_in[16*c +: 16] = col_scaled[c][51:36];
      end
   end

   // ------------------------------------------------------------ exponentials
   gsp_exp_pipe u_exp_size (
      .clock   (clock),
      .exp_arg (arg_pk_ff),
      .exp_res (size_exp)
   );

   for (genvar j = 0; j < 3; j++) begin : g_col_exp
      gsp_exp_pipe u_exp_col (
         .clock   (clock),
         .exp_arg (arg_m_ff[j]),
         .exp_res (col_exp[j])
      );
   end

   gsp_exp_pipe u_exp_alpha (
      .clock   (clock),
      .exp_arg (arg_a_ff),
      .exp_res (alpha_exp)
   );

   // ---------------------------------------------------------------- rotation
   assign qd = quat_dly_ff[QUAT_DLY-1];

   always_comb begin
      rot_in[0] = ROT_ONE - ((34'(p_yy_ff) + 34'(p_zz_ff)) <<< 1);
      rot_in[1] = (34'(p_xy_ff) - 34'(p_zw_ff)) <<< 1;
      rot_in[2] = (34'(p_xz_ff) + 34'(p_yw_ff)) <<< 1;
      rot_in[3] = (34'(p_xy_ff) + 34'(p_zw_ff)) <<< 1;
      rot_in[4] = ROT_ONE - ((34'(p_xx_ff) + 34'(p_zz_ff)) <<< 1);
      rot_in[5] = (34'(p_yz_ff) - 34'(p_xw_ff)) <<< 1;
      rot_in[6] = (34'(p_xz_ff) - 34'(p_yw_ff)) <<< 1;
      rot_in[7] = (34'(p_yz_ff) + 34'(p_xw_ff)) <<< 1;
      rot_in[8] = ROT_ONE - ((34'(p_xx_ff) + 34'(p_yy_ff)) <<< 1);
   end

   // ------------------------------------------- matrix shift and saturation
   always_comb begin
      mrow_in = '0;
      for (int e = 0; e < 9; e++) begin
         mshift[e] = mprod_ff[e] >> (6'd62 - kcol_ff[e % 3]);
         if (neg42_ff[e]) begin
            // saturate magnitude at 32768, then negate
            ment[e] = (mshift[e] > 64'd32768) ? 16'h8000 : (16'd0 - mshift[e][15:0]);
         end else begin
            ment[e] = (mshift[e] > 64'd32767) ? 16'h7FFF : mshift[e][15:0];
         end
         mrow_in[e / 3][16*(e % 3) +: 16] = ment[e];
      end
   end

   // the size exponent never exceeds 23, so the product only shifts right
   assign psshift = psprod_ff >> (6'd34 - pk42_ff);
   assign ps_in   = (|psshift[47:32]) ? 32'hFFFF_FFFF : psshift[31:0];

   // ------------------------------------------------------- sigmoid divider
   assign ek      = alpha_exp.expo;
   assign dscaled = (ek >= 6'd12) ? (44'(alpha_exp.mant) << (ek - 6'd12))
                                  : (44'(alpha_exp.mant) >> (6'd12 - ek));

   always_comb begin
      // divisor 1 + exp(-logit) in Q30, dividend 65535 in Q30 plus half
      dv_d_in[0]   = (44'd1 << 30) + dscaled;
      dv_rem_in[0] = 47'(64'd65535 << 30) + 47'(dv_d_in[0] >> 1);
      dv_q_in[0]   = '0;
      dv_sub[0]    = '0;
      for (int n = 1; n <= DIV_BITS; n++) begin
         dv_sub[n]  = 60'(dv_d_ff[n-1]) << (DIV_BITS - n);
         dv_d_in[n] = dv_d_ff[n-1];
         if (60'(dv_rem_ff[n-1]) >= dv_sub[n]) begin
            dv_rem_in[n] = 47'(60'(dv_rem_ff[n-1]) - dv_sub[n]);
            dv_q_in[n]   = dv_q_ff[n-1] | (16'd1 << (DIV_BITS - n));
         end else begin
            dv_rem_in[n] = dv_rem_ff[n-1];
            dv_q_in[n]   = dv_q_ff[n-1];
         end
      end
   end

   // --------------------------------------------------------- datapath regs
   always_ff @(posedge clock) begin
      // stage 0: capture the splat
      pos_ff   <= req_position;
      ls_ff[0] <= req_log_scale_x;
      ls_ff[1] <= req_log_scale_y;
      ls_ff[2] <= req_log_scale_z;
      quat_ff  <= '{w: req_quat_w, x: req_quat_x, y: req_quat_y, z: req_quat_z};
      sh_ff    <= req_sh_dc_rgb;
      logit_ff <= req_opacity_logit;

      // stage 1: exponent arguments; max/scale_j = exp(lmax - ls_j)
      arg_pk_ff <= 18'(lmax);
      for (int j = 0; j < 3; j++) begin
         arg_m_ff[j] <= 18'(lmax) - 18'(ls_ff[j]);
         col_t_ff[j] <= col_t_in[j];
      end
      arg_a_ff <= -18'(logit_ff);

      // stage 2: colour
      col_c_ff <= col_c_in;

      // delay lines
      ctr_dly_ff[0] <= pos_ff;
      for (int n = 1; n < CTR_DLY; n++) begin
         ctr_dly_ff[n] <= ctr_dly_ff[n-1];
      end
      col_dly_ff[0] <= col_c_ff;
      for (int n = 1; n < COL_DLY; n++) begin
         col_dly_ff[n] <= col_dly_ff[n-1];
      end
      quat_dly_ff[0] <= quat_ff;
      for (int n = 1; n < QUAT_DLY; n++) begin
         quat_dly_ff[n] <= quat_dly_ff[n-1];
      end

      // rotation: products, entries, sign and magnitude
      p_xx_ff <= 32'(qd.x) * 32'(qd.x);
      p_yy_ff <= 32'(qd.y) * 32'(qd.y);
      p_zz_ff <= 32'(qd.z) * 32'(qd.z);
      p_xy_ff <= 32'(qd.x) * 32'(qd.y);
      p_xz_ff <= 32'(qd.x) * 32'(qd.z);
      p_yz_ff <= 32'(qd.y) * 32'(qd.z);
      p_xw_ff <= 32'(qd.x) * 32'(qd.w);
      p_yw_ff <= 32'(qd.y) * 32'(qd.w);
      p_zw_ff <= 32'(qd.z) * 32'(qd.w);
      for (int e = 0; e < 9; e++) begin
         rot_ff[e] <= rot_in[e];
         neg_ff[e] <= rot_ff[e][33];
         mag_ff[e] <= rot_ff[e][33] ? 33'(-rot_ff[e]) : 33'(rot_ff[e]);
      end

      // stage 42: products against the exponentials
      for (int e = 0; e < 9; e++) begin
         mprod_ff[e] <= 64'(mag_ff[e]) * 64'(col_exp[e % 3].mant);
         neg42_ff[e] <= neg_ff[e];
      end
      for (int j = 0; j < 3; j++) begin
         kcol_ff[j] <= col_exp[j].expo;
      end
      psprod_ff <= 48'(size_exp.mant) * 48'(scale_ff);
      pk42_ff   <= size_exp.expo;

      // stage 43: shift and saturate
      mrow_ff <= mrow_in;
      ps_ff   <= ps_in;
      mrow_dly_ff[0] <= mrow_ff;
      ps_dly_ff[0]   <= ps_ff;
      for (int n = 1; n < MAT_DLY; n++) begin
         mrow_dly_ff[n] <= mrow_dly_ff[n-1];
         ps_dly_ff[n]   <= ps_dly_ff[n-1];
      end

      // divider: one quotient bit per stage
      for (int n = 0; n <= DIV_BITS; n++) begin
         dv_rem_ff[n] <= dv_rem_in[n];
         dv_d_ff[n]   <= dv_d_in[n];
         dv_q_ff[n]   <= dv_q_in[n];
      end

      // output registers
      rsp_center_ff     <= ctr_dly_ff[CTR_DLY-1];
      rsp_point_size_ff <= ps_dly_ff[MAT_DLY-1];
      rsp_mrow_ff       <= mrow_dly_ff[MAT_DLY-1];
      rsp_color_ff      <= {dv_q_ff[DIV_BITS], col_dly_ff[COL_DLY-1]};
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_center      = rsp_center_ff;
   assign rsp_point_size  = rsp_point_size_ff;
   assign rsp_matrix_row0 = rsp_mrow_ff[0];
   assign rsp_matrix_row1 = rsp_mrow_ff[1];
   assign rsp_matrix_row2 = rsp_mrow_ff[2];
   assign rsp_color_rgba  = rsp_color_ff;

endmodule

`default_nettype wire

[rtl/gsp_exp_pipe.sv]
// ----------------------------------------------------------------------------
// gsp_exp_pipe: pipelined fixed-point exponential
// Splits exp(v/4096) into a Q30 mantissa and a power of two; one argument
// enters every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_exp_pipe (
   input  logic                    clock,
   input  logic signed [17:0]      exp_arg,
   output gsp_pkg::exp_result_type exp_res
);

   localparam int NT = gsp_pkg::TAYLOR_TERMS;

   // range reduction
   logic [46:0] w_full;
   logic [44:0] w1_ff;
   logic [44:0] w2_ff;
   logic [5:0]  qe2_in;
   logic [5:0]  qe2_ff;
   logic [45:0] qe_prod;
   logic [40:0] rem3_in;
   logic [40:0] rem3_ff;
   logic [5:0]  k3_ff;
   logic        over4;
   logic [40:0] red4;
   logic [5:0]  k4_ff;
   logic [29:0] r4_ff;

   // Taylor steps: multiply, divide estimate, divide correction
   logic [30:0] term_src [NT];
   logic [31:0] sum_src  [NT];
   logic [29:0] r_src    [NT];
   logic [5:0]  k_src    [NT];

   logic [60:0] prod_a_ff [NT];
   logic [31:0] sum_a_ff  [NT];
   logic [29:0] r_a_ff    [NT];
   logic [5:0]  k_a_ff    [NT];

   logic [30:0] est_b_in  [NT];
   logic [30:0] t_b_ff    [NT];
   logic [30:0] est_b_ff  [NT];
   logic [31:0] sum_b_ff  [NT];
   logic [29:0] r_b_ff    [NT];
   logic [5:0]  k_b_ff    [NT];

   logic [34:0] rem_c     [NT];
   logic [30:0] term_c_in [NT];
   logic [30:0] term_c_ff [NT];
   logic [31:0] sum_c_ff  [NT];
   logic [29:0] r_c_ff    [NT];
   logic [5:0]  k_c_ff    [NT];

   assign w_full  = (47'(exp_arg) <<< 28) + 47'(gsp_pkg::EXP_OFFSET);
   assign qe2_in  = 6'((46'(w1_ff[44:20]) * 46'(gsp_pkg::K_RECIP)) >> 40);
   assign qe_prod = 46'(qe2_ff) * 46'(gsp_pkg::LN2_Q40);
   assign rem3_in = 41'(46'(w2_ff) - qe_prod);
   assign over4   = rem3_ff >= 41'(gsp_pkg::LN2_Q40);
   assign red4    = over4 ? (rem3_ff - 41'(gsp_pkg::LN2_Q40)) : rem3_ff;

   always_comb begin
      for (int g = 0; g < NT; g++) begin
         if (g == 0) begin
            term_src[g] = 31'd1 << 30;
            sum_src[g]  = 32'd1 << 30;
            r_src[g]    = r4_ff;
            k_src[g]    = k4_ff;
         end else begin
            term_src[g] = term_c_ff[g-1];
            sum_src[g]  = sum_c_ff[g-1];
            r_src[g]    = r_c_ff[g-1];
            k_src[g]    = k_c_ff[g-1];
         end
         // estimate is low by at most one
         est_b_in[g]  = 31'((63'(prod_a_ff[g][60:30]) * 63'(gsp_pkg::TAYLOR_RECIP[g])) >> 31);
         rem_c[g]     = 35'(t_b_ff[g]) - 35'(est_b_ff[g]) * 35'(g + 1);
         term_c_in[g] = est_b_ff[g] + 31'(rem_c[g] >= 35'(g + 1));
      end
   end

   always_ff @(posedge clock) begin
      w1_ff   <= w_full[44:0];
      w2_ff   <= w1_ff;
      qe2_ff  <= qe2_in;
      rem3_ff <= rem3_in;
      k3_ff   <= qe2_ff;
      k4_ff   <= over4 ? (k3_ff + 6'd1) : k3_ff;
      r4_ff   <= red4[39:10];
      for (int g = 0; g < NT; g++) begin
         prod_a_ff[g] <= 61'(term_src[g]) * 61'(r_src[g]);
         sum_a_ff[g]  <= sum_src[g];
         r_a_ff[g]    <= r_src[g];
         k_a_ff[g]    <= k_src[g];

         t_b_ff[g]    <= prod_a_ff[g][60:30];
         est_b_ff[g]  <= est_b_in[g];
         sum_b_ff[g]  <= sum_a_ff[g];
         r_b_ff[g]    <= r_a_ff[g];
         k_b_ff[g]    <= k_a_ff[g];

         term_c_ff[g] <= term_c_in[g];
         sum_c_ff[g]  <= sum_b_ff[g] + 32'(term_c_in[g]);
         r_c_ff[g]    <= r_b_ff[g];
         k_c_ff[g]    <= k_b_ff[g];
      end
   end

   assign exp_res.mant = sum_c_ff[NT-1];
   assign exp_res.expo = k_c_ff[NT-1];

endmodule

`default_nettype wire

[tb/sv/tb_gaussian_splat_preprocess_top.sv]
// ----------------------------------------------------------------------------
// tb_gaussian_splat_preprocess_top: self-checking bench of the splat preprocessor
// Streams splats in bursts under several point-size scale settings, predicts
// every result in fixed point and checks each field against the block.
// ----------------------------------------------------------------------------
module tb_gaussian_splat_preprocess_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned LN2_FIX = 64'hB1_7217_F7D2;  // ln2 in Q40
   localparam longint C0_FIX = 4732765;                       // 1/(2*sqrt(pi)) in Q24
   localparam longint ONE_ROT = 64'sd1 << 28;
   localparam int DRAIN_CYCLES = 80;      // pipeline is 60 deep
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_PER_PHASE = 365;

   typedef struct {
      logic [47:0]        pos;
      logic signed [15:0] lsx, lsy, lsz;
      logic signed [15:0] qw, qx, qy, qz;
      logic [47:0]        sh;
      logic signed [15:0] logit;
   } splat_type;

   typedef struct {
      logic [47:0] center;
      logic [31:0] size;
      logic [47:0] row0, row1, row2;
      logic [63:0] rgba;
   } splat_out_type;

   // -------------------------------------------------------------------------
   // Scoreboard: fixed-point predictor plus the queue of pending results
   // -------------------------------------------------------------------------
   class splat_scoreboard;
      splat_out_type pending_q[$];
      int unsigned size_scale = 256;
      int unsigned mismatches = 0;

      // exp(v/4096) = m * 2^(k-42), m in Q30
      function automatic void exp_q30(input longint v, output longint unsigned m,
                                      output int unsigned k);
         longint unsigned uw, kk, r, term, sum;
         uw = v * 64'd268435456 + 64'd12 * LN2_FIX;
         kk = uw / LN2_FIX;
         r = (uw - kk * LN2_FIX) >> 10;
         term = 64'd1 << 30;
         sum = term;
         for (int i = 1; i <= 12; i++) begin
            term = ((term * r) >> 30) / i;
            sum += term;
         end
         m = sum;
         k = int'(kk);
      endfunction

      function automatic logic [15:0] scaled_entry(input longint r, input longint unsigned m,
                                                    input int unsigned k);
         longint unsigned mag;
         mag = (r < 0) ? longint'(-r) : r;
         mag = (mag * m) >> (62 - k);
         if (r < 0) begin
            if (mag > 32768) mag = 32768;
            return 16'(65536 - mag);
         end
         if (mag > 32767) mag = 32767;
         return 16'(mag);
      endfunction

      function automatic logic [15:0] color_channel(input logic signed [15:0] dc);
         longint t;
         longint unsigned u;
         t = longint'(dc) * C0_FIX + (64'sd1 << 35);
         if (t < 0) t = 0;
         if (t > (64'sd1 << 36)) t = 64'sd1 << 36;
         u = t;
         return 16'((u * 65535 + (64'd1 << 35)) >> 36);
      endfunction

      function automatic splat_out_type predict(input splat_type s);
         splat_out_type o;
         longint ls[3], lmax, w, x, y, z;
         longint rot[3][3];
         longint unsigned m[3], pm, ps, em, d;
         int unsigned k[3], pk, ek;
         logic [47:0] rows[3];
         ls[0] = longint'(s.lsx); ls[1] = longint'(s.lsy); ls[2] = longint'(s.lsz);
         w = longint'(s.qw); x = longint'(s.qx); y = longint'(s.qy); z = longint'(s.qz);
         lmax = ls[0];
         if (ls[1] > lmax) lmax = ls[1];
         if (ls[2] > lmax) lmax = ls[2];
         o.center = s.pos;

         exp_q30(lmax, pm, pk);
         ps = pm * size_scale;
         if (pk <= 34) ps = ps >> (34 - pk);
         else ps = (ps > (64'hFFFF_FFFF >> (pk - 34))) ? 64'hFFFF_FFFF : ps << (pk - 34);
         o.size = (ps > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(ps);

         rot[0][0] = ONE_ROT - 2 * (y * y + z * z);
         rot[0][1] = 2 * (x * y - z * w);
         rot[0][2] = 2 * (x * z + y * w);
         rot[1][0] = 2 * (x * y + z * w);
         rot[1][1] = ONE_ROT - 2 * (x * x + z * z);
         rot[1][2] = 2 * (y * z - x * w);
         rot[2][0] = 2 * (x * z - y * w);
         rot[2][1] = 2 * (y * z + x * w);
         rot[2][2] = ONE_ROT - 2 * (x * x + y * y);
         for (int j = 0; j < 3; j++) exp_q30(lmax - ls[j], m[j], k[j]);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               rows[i][16*j +: 16] = scaled_entry(rot[i][j], m[j], k[j]);
         o.row0 = rows[0]; o.row1 = rows[1]; o.row2 = rows[2];

         o.rgba[15:0]  = color_channel(s.sh[15:0]);
         o.rgba[31:16] = color_channel(s.sh[31:16]);
         o.rgba[47:32] = color_channel(s.sh[47:32]);
         exp_q30(-longint'(s.logit), em, ek);
         d = (64'd1 << 30) + ((ek >= 12) ? (em << (ek - 12)) : (em >> (12 - ek)));
         o.rgba[63:48] = 16'((64'd65535 * (64'd1 << 30) + d / 2) / d);
         return o;
      endfunction

      function void note_splat(input splat_type s);
         pending_q.insert(pending_q.size(), predict(s));
      endfunction

      function void check_result(input splat_out_type got);
         splat_out_type exp_o;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result center=%h", got.center);
            return;
         end
         exp_o = pending_q.pop_front();
         if (got.center !== exp_o.center || got.size !== exp_o.size ||
             got.row0 !== exp_o.row0 || got.row1 !== exp_o.row1 ||
             got.row2 !== exp_o.row2 || got.rgba !== exp_o.rgba) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at %0t", $realtime);
               $display("  center exp %h got %h", exp_o.center, got.center);
               $display("  size   exp %h got %h", exp_o.size, got.size);
               $display("  row0   exp %h got %h", exp_o.row0, got.row0);
               $display("  row1   exp %h got %h", exp_o.row1, got.row1);
               $display("  row2   exp %h got %h", exp_o.row2, got.row2);
               $display("  rgba   exp %h got %h", exp_o.rgba, got.rgba);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [47:0]        req_position = '0;
   logic signed [15:0] req_log_scale_x = '0, req_log_scale_y = '0, req_log_scale_z = '0;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic [47:0]        req_sh_dc_rgb = '0;
   logic signed [15:0] req_opacity_logit = '0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [15:0]        csr_wdata = '0;
   logic               rsp_strobe;
   logic [47:0]        rsp_center, rsp_matrix_row0, rsp_matrix_row1, rsp_matrix_row2;
   logic [31:0]        rsp_point_size;
   logic [63:0]        rsp_color_rgba;

   gaussian_splat_preprocess_top i_dut (
      .clock, .reset, .start, .busy,
      .req_position, .req_log_scale_x, .req_log_scale_y, .req_log_scale_z,
      .req_quat_w, .req_quat_x, .req_quat_y, .req_quat_z,
      .req_sh_dc_rgb, .req_opacity_logit,
      .csr_valid, .csr_ready, .csr_wdata,
      .rsp_strobe, .rsp_center, .rsp_point_size,
      .rsp_matrix_row0, .rsp_matrix_row1, .rsp_matrix_row2, .rsp_color_rgba
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   splat_scoreboard sb = new();
   int unsigned cycle_count = 0;

   // -------------------------------------------------------------------------
   // Monitor: everything is sampled on the rising edge, before the block and
   // the drivers update their outputs for the next cycle
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      splat_type     s;
      splat_out_type r;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset) begin
         // apply the register write first, it only happens while idle
         if (csr_valid && csr_ready) sb.size_scale = 32'(csr_wdata);
         if (start && !busy) begin
            s.pos = req_position;
            s.lsx = req_log_scale_x; s.lsy = req_log_scale_y; s.lsz = req_log_scale_z;
            s.qw = req_quat_w; s.qx = req_quat_x; s.qy = req_quat_y; s.qz = req_quat_z;
            s.sh = req_sh_dc_rgb;
            s.logit = req_opacity_logit;
            sb.note_splat(s);
         end
         if (rsp_strobe) begin
            r.center = rsp_center;
            r.size = rsp_point_size;
            r.row0 = rsp_matrix_row0;
            r.row1 = rsp_matrix_row1;
            r.row2 = rsp_matrix_row2;
            r.rgba = rsp_color_rgba;
            sb.check_result(r);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   int burst_left = 0;

   // Hold start high through a burst; drop it only for a gap, so start never
   // gets two assignments in one step.
   task automatic send_splat(input splat_type s);
      int gap;
      if (burst_left == 0) begin
         // one burst in four runs with no gap at all
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start             <= 1'b1;
      req_position      <= s.pos;
      req_log_scale_x   <= s.lsx;
      req_log_scale_y   <= s.lsy;
      req_log_scale_z   <= s.lsz;
      req_quat_w        <= s.qw;
      req_quat_x        <= s.qx;
      req_quat_y        <= s.qy;
      req_quat_z        <= s.qz;
      req_sh_dc_rgb     <= s.sh;
      req_opacity_logit <= s.logit;
      do @(posedge clock); while (busy);
   endtask

   // Drop start, let the pipeline empty, then idle a little longer.
   task automatic drain();
      start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size_scale(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic splat_type make_splat(input logic [15:0] ls, input logic [15:0] q,
                                            input logic [15:0] dc, input logic [15:0] lg);
      splat_type s;
      s.pos = 48'({$urandom, $urandom});
      s.lsx = ls; s.lsy = ls; s.lsz = ls;
      s.qw = q; s.qx = q; s.qy = q; s.qz = q;
      s.sh = {dc, dc, dc};
      s.logit = lg;
      return s;
   endfunction

   // Mostly plausible splats (moderate scales, quaternion parts in [-1, 1],
   // colours close to the clamp range); the rest raw bits across the full range.
   function automatic splat_type random_splat();
      splat_type s;
      s.pos = 48'({$urandom, $urandom});
      if ($urandom_range(0, 9) < 7) begin
         s.lsx = 16'($urandom_range(0, 24576)) - 16'sd16384;
         s.lsy = 16'($urandom_range(0, 24576)) - 16'sd16384;
         s.lsz = 16'($urandom_range(0, 24576)) - 16'sd16384;
         s.qw = 16'($urandom_range(0, 32768)) - 16'sd16384;
         s.qx = 16'($urandom_range(0, 32768)) - 16'sd16384;
         s.qy = 16'($urandom_range(0, 32768)) - 16'sd16384;
         s.qz = 16'($urandom_range(0, 32768)) - 16'sd16384;
         s.sh = {16'($urandom_range(0, 16384)) - 16'd8192,
                 16'($urandom_range(0, 16384)) - 16'd8192,
                 16'($urandom_range(0, 16384)) - 16'd8192};
         s.logit = 16'($urandom_range(0, 65535));
      end else begin
         s.lsx = 16'($urandom); s.lsy = 16'($urandom); s.lsz = 16'($urandom);
         s.qw = 16'($urandom); s.qx = 16'($urandom);
         s.qy = 16'($urandom); s.qz = 16'($urandom);
         s.sh = 48'({$urandom, $urandom});
         s.logit = 16'($urandom);
      end
      return s;
   endfunction

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [15:0] scales[4];
      splat_type s;
      scales = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0100};
      scales[2] = 16'($urandom_range(1, 65534));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: run at the reset scale first
      s = make_splat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_splat(s);
      s = make_splat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_splat(s);
      s = make_splat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_splat(s);
      s = make_splat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_splat(s);
      // identity quaternion, equal scales
      s = make_splat(16'h1000, 16'h0000, 16'h0000, 16'h0000);
      s.qw = 16'sd16384;
      send_splat(s);
      // widest spread between axes: matrix columns saturate
      s = make_splat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      s.lsx = 16'sh7FFF; s.lsy = 16'sh8000; s.lsz = 16'sh8000;
      s.qw = 16'sd16384;
      send_splat(s);
      s.lsx = 16'sh8000; s.lsz = 16'sh7FFF;
      s.qw = 16'sh8000; s.qx = 16'sh7FFF; s.qy = 16'sh8000; s.qz = 16'sh7FFF;
      send_splat(s);
      // unnormalized quaternions with negative entries
      s = make_splat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
      s.qw = 16'sh8000;
      send_splat(s);
      // colour below zero, above one and mid; alpha extremes
      s = make_splat(16'h0000, 16'h0000, 16'h8000, 16'h8000);
      s.sh = {16'h7FFF, 16'h0000, 16'h8000};
      send_splat(s);
      s.sh = {16'hE3A0, 16'h1C5F, 16'h0001};
      s.logit = 16'sh7FFF;
      send_splat(s);
      drain();

      // Random phases, one per scale setting, extremes included
      foreach (scales[p]) begin
         write_size_scale(scales[p]);
         if (p == 0) begin
            // saturate the point size at the largest scale
            s = make_splat(16'h7FFF, 16'h4000, 16'h0000, 16'h0000);
            send_splat(s);
            s = make_splat(16'h8000, 16'h4000, 16'h0000, 16'h0000);
            send_splat(s);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) send_splat(random_splat());
         drain();
      end

      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
